// ===== hdl/spcps_pkg.sv =====
// shared types, constants and helpers for the spi clock prescaler search unit
// used by spcps_ctrl, spcps_dpath and spi_clock_prescaler_search_unit
// no dependencies
package spcps_pkg;

  localparam int REQ_W       = 32;
  localparam int RATE_W      = 32;
  localparam int PCODE_W     = 2;
  localparam int SCODE_W     = 3;
  localparam int CAND_W      = PCODE_W + SCODE_W;
  localparam int DIVR_W      = 10;
  localparam int BITCNT_W    = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_INSTR_CLOCK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LINK    = 1'b1;

  localparam logic [CFG_DATA_W-1:0] INSTR_CLOCK_RST = 32'd40000000;
  localparam logic [CFG_DATA_W-1:0] MAX_LINK_RST    = 32'd10000000;

  // primary prescaler codes
  localparam logic [PCODE_W-1:0] PRI_DIV64 = 2'd0;
  localparam logic [PCODE_W-1:0] PRI_DIV16 = 2'd1;
  localparam logic [PCODE_W-1:0] PRI_DIV4  = 2'd2;
  localparam logic [PCODE_W-1:0] PRI_DIV1  = 2'd3;

  localparam logic [CAND_W-1:0]   LAST_CAND = {CAND_W{1'b1}};
  localparam logic [BITCNT_W-1:0] LAST_BIT  = {BITCNT_W{1'b1}};

  typedef struct packed {
    logic               load_req;
    logic               div_init;
    logic               div_step;
    logic               eval;
    logic               out_load;
    logic [PCODE_W-1:0] pcode;
    logic [SCODE_W-1:0] scode;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
  } dp_stat_t;

  // combined divisor: primary divisor times (8 - secondary code)
  function automatic logic [DIVR_W-1:0] cand_divisor(input logic [PCODE_W-1:0] pcode,
                                                     input logic [SCODE_W-1:0] scode);
    logic [3:0] sec;
    sec = 4'd8 - {1'b0, scode};
    case (pcode)
      PRI_DIV64: cand_divisor = {sec, 6'b0};
      PRI_DIV16: cand_divisor = {2'b0, sec, 4'b0};
      PRI_DIV4:  cand_divisor = {4'b0, sec, 2'b0};
      default:   cand_divisor = {6'b0, sec};
    endcase
  endfunction

endpackage

// ===== hdl/spcps_ctrl.sv =====
// sequencer for the prescaler search: walks the 32 candidates and the divider bits
// depends on spcps_pkg
module spcps_ctrl import spcps_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INIT = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_EVAL = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]          state, state_next;
  logic [CAND_W-1:0]   cand, cand_next;
  logic [BITCNT_W-1:0] bit_cnt, bit_cnt_next;
  logic                out_valid_next;

  always_comb begin
    state_next     = state;
    cand_next      = cand;
    bit_cnt_next   = bit_cnt;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.pcode      = cand[CAND_W-1:SCODE_W];
    cmd.scode      = cand[SCODE_W-1:0];
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          cand_next    = '0;
          state_next   = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.div_init = 1'b1;
        bit_cnt_next = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        bit_cnt_next = bit_cnt + 1'b1;
        if (bit_cnt == LAST_BIT) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        // an exact match ends the search at once
        if (stat.hit || cand == LAST_CAND) begin
          state_next = ST_DONE;
        end else begin
          cand_next  = cand + 1'b1;
          state_next = ST_INIT;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cand      <= '0;
      bit_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cand      <= cand_next;
      bit_cnt   <= bit_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_INIT && cand == '0))
    else $error("search did not start at the first candidate");

  a_div_to_eval: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && bit_cnt == LAST_BIT) |=> (state == ST_EVAL))
    else $error("divider did not hand over to evaluation");

  a_cand_advance: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL && !stat.hit && cand != LAST_CAND) |=>
      (cand == $past(cand) + 1'b1 && state == ST_INIT))
    else $error("candidate counter did not advance");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

endmodule

// ===== hdl/spcps_dpath.sv =====
// datapath: config registers, bit-serial divider, best-candidate tracking, result register
// depends on spcps_pkg
module spcps_dpath import spcps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [REQ_W-1:0]      requested_bps,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic [RATE_W-1:0]     achieved_bps,
  output logic [PCODE_W-1:0]    primary_code,
  output logic [SCODE_W-1:0]    secondary_code,
  output logic                  found
);

  logic [CFG_DATA_W-1:0] instr_clock_hz;
  logic [CFG_DATA_W-1:0] max_link_bps;

  logic [REQ_W-1:0]   req;
  logic [DIVR_W-1:0]  divisor;
  logic [DIVR_W-1:0]  rem;
  logic [RATE_W-1:0]  quo;
  logic [RATE_W-1:0]  best;
  logic [PCODE_W-1:0] best_p;
  logic [SCODE_W-1:0] best_s;
  logic               hit;

  logic [DIVR_W:0]   partial;
  logic [DIVR_W+1:0] diff;
  logic              borrow;
  logic              exact;
  logic              better;

  always_ff @(posedge clk) begin
    if (rst) begin
      instr_clock_hz <= INSTR_CLOCK_RST;
      max_link_bps   <= MAX_LINK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INSTR_CLOCK: instr_clock_hz <= cfg_data;
        REG_MAX_LINK:    max_link_bps   <= cfg_data;
        default:         ;
      endcase
    end
  end

  // restoring division, one quotient bit per cycle; remainder stays below the divisor
  assign partial = {rem, quo[RATE_W-1]};
  assign diff    = {1'b0, partial} - {2'b0, divisor};
  assign borrow  = diff[DIVR_W+1];

  assign exact    = (quo == req);
  assign better   = (req > quo) && (quo > best) && (quo <= max_link_bps);
  assign stat.hit = exact;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req <= requested_bps;
    end
    if (cmd.div_init) begin
      divisor <= cand_divisor(cmd.pcode, cmd.scode);
      rem     <= '0;
      quo     <= instr_clock_hz;
    end else if (cmd.div_step) begin
      rem <= borrow ? partial[DIVR_W-1:0] : diff[DIVR_W-1:0];
      quo <= {quo[RATE_W-2:0], ~borrow};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      best   <= '0;
      best_p <= '0;
      best_s <= '0;
      hit    <= 1'b0;
    end else if (cmd.eval && (exact || better)) begin
      best   <= quo;
      best_p <= cmd.pcode;
      best_s <= cmd.scode;
      hit    <= exact;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      achieved_bps   <= best;
      primary_code   <= best_p;
      secondary_code <= best_s;
      found          <= hit || (best != '0);
    end
  end

endmodule

// ===== hdl/spi_clock_prescaler_search_unit.sv =====
// Picks the primary (div 64/16/4/1) and secondary (div 8..1) prescaler pair for a
// requested bit rate. One request is searched at a time: each of up to 32 candidates
// takes a divider load, 32 steps of a bit-serial 32-bit divider and an evaluation;
// an exact match ends the search early. The finished result sits in an output
// register, so the next request can be accepted while it waits to be taken.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user must
// write it only while the unit is idle, which the unit itself does not enforce.
// depends on spcps_pkg, spcps_ctrl, spcps_dpath
module spi_clock_prescaler_search_unit import spcps_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [31:0] requested_bps
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [31:0] achieved_bps, [33:32] primary_code, [36:34] secondary_code, [37] found,
  // [39:38] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic [RATE_W-1:0]  achieved_bps;
  logic [PCODE_W-1:0] primary_code;
  logic [SCODE_W-1:0] secondary_code;
  logic               found;

  spcps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  spcps_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .requested_bps  (s_axis_tdata[REQ_W-1:0]),
    .cmd            (cmd),
    .stat           (stat),
    .achieved_bps   (achieved_bps),
    .primary_code   (primary_code),
    .secondary_code (secondary_code),
    .found          (found)
  );

  assign m_axis_tdata = {2'b00, found, secondary_code, primary_code, achieved_bps};

endmodule

// ===== dv/spi_clock_prescaler_search_unit_test.sv =====
// Testbench for spi_clock_prescaler_search_unit: sends rate requests over the
// input stream, predicts each chosen prescaler pair and checks the output stream.
// Depends on spcps_pkg and the RTL under hdl/.
`timescale 1ns / 100ps

module spi_clock_prescaler_search_unit_test;
  import spcps_pkg::*;

  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 65;

  typedef struct packed {
    logic [RATE_W-1:0]  rate;
    logic [PCODE_W-1:0] pri;
    logic [SCODE_W-1:0] sec;
    logic               found;
  } prescaler_pick_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_INSTR_CLOCK;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [31:0] requested_bps
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [31:0] achieved_bps, [33:32] primary_code, [36:34] secondary_code, [37] found,
  // [39:38] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // local copy of the configuration registers
  logic [31:0] clock_hz = INSTR_CLOCK_RST;
  logic [31:0] link_limit_bps = MAX_LINK_RST;

  prescaler_pick_t pending_picks[$];
  int unsigned     cycle_count = 0;
  int              error_count = 0;
  int              requests_sent = 0;
  int              results_seen = 0;
  int              found_seen = 0;
  int              settings_used = 1;
  bit              in_idle_on = 1'b1;
  bit              out_idle_on = 1'b1;
  int              ready_hold = 0;

  spi_clock_prescaler_search_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               pending_picks.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // rate of one primary/secondary pair at the current instruction clock
  function automatic logic [31:0] candidate_rate(input logic [PCODE_W-1:0] pri,
                                                 input logic [SCODE_W-1:0] sec);
    logic [31:0] div;
    div = 32'd8 - {29'd0, sec};
    case (pri)
      PRI_DIV64: div = div << 6;
      PRI_DIV16: div = div << 4;
      PRI_DIV4:  div = div << 2;
      default:   div = div;
    endcase
    return clock_hz / div;
  endfunction

  // exact match wins at once; otherwise highest rate below request and within limit
  function automatic prescaler_pick_t pick_prescaler(input logic [31:0] req);
    prescaler_pick_t pick;
    logic [31:0]     rate;
    bit              hit;
    int              p;
    int              s;
    pick = '0;
    hit = 1'b0;
    for (p = 0; p < 4 && !hit; p++) begin
      for (s = 0; s < 8 && !hit; s++) begin
        rate = candidate_rate(p[PCODE_W-1:0], s[SCODE_W-1:0]);
        if (rate == req) begin
          pick.rate = rate;
          pick.pri = p[PCODE_W-1:0];
          pick.sec = s[SCODE_W-1:0];
          hit = 1'b1;
        end else if (req > rate && rate > pick.rate && rate <= link_limit_bps) begin
          pick.rate = rate;
          pick.pri = p[PCODE_W-1:0];
          pick.sec = s[SCODE_W-1:0];
        end
      end
    end
    pick.found = hit || (pick.rate != 0);
    return pick;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= 20)
      $display("mismatch in %s at cycle %0d: got %0d, expected %0d", what, cycle_count,
               got, want);
  endtask

  task automatic send_request(input logic [31:0] req);
    s_axis_tdata <= req;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_picks.push_back(pick_prescaler(req));
    requests_sent++;
    if (in_idle_on && $urandom_range(0, 99) < 18) begin
      s_axis_tvalid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(30, 1100) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_INSTR_CLOCK) clock_hz = value;
    else link_limit_bps = value;
    settings_used++;
  endtask

  // half the requests on or next to a candidate rate, the rest spread wide or very small
  function automatic logic [31:0] random_request();
    logic [31:0] base;
    base = candidate_rate(PCODE_W'($urandom_range(0, 3)), SCODE_W'($urandom_range(0, 7)));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return base + $urandom_range(0, 4) - 2;
      4:          return base;
      5, 6:       return $urandom;
      7, 8:       return $urandom_range(0, clock_hz);
      default:    return $urandom_range(0, 16);
    endcase
  endfunction

  // output side backpressure
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_idle_on && $urandom_range(0, 99) < 18) begin
      m_axis_tready <= 1'b0;
      ready_hold <= ($urandom_range(0, 39) == 0) ? $urandom_range(20, 1200)
                                                  : $urandom_range(0, 3);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    prescaler_pick_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_picks.size() == 0) begin
        report_mismatch("unexpected transaction", m_axis_tdata[31:0], 32'd0);
      end else begin
        want = pending_picks.pop_front();
        results_seen++;
        if (want.found) found_seen++;
        if (m_axis_tdata[31:0] !== want.rate)
          report_mismatch("achieved_bps", m_axis_tdata[31:0], want.rate);
        if (m_axis_tdata[33:32] !== want.pri)
          report_mismatch("primary_code", 32'(m_axis_tdata[33:32]), 32'(want.pri));
        if (m_axis_tdata[36:34] !== want.sec)
          report_mismatch("secondary_code", 32'(m_axis_tdata[36:34]), 32'(want.sec));
        if (m_axis_tdata[37] !== want.found)
          report_mismatch("found", 32'(m_axis_tdata[37]), 32'(want.found));
        if (m_axis_tdata[39:38] !== 2'b00)
          report_mismatch("padding bits", 32'(m_axis_tdata[39:38]), 32'd0);
      end
    end
  end

  task automatic test_reset_settings();
    send_request(32'd78125);       // exact on the slowest pair
    send_request(32'd10000000);    // exact at the limit
    send_request(32'd40000000);    // exact above the limit
    send_request(32'd39999999);
    send_request(32'd78126);
    send_request(32'd78124);
    send_request(32'd1);           // nothing fits
    send_request(32'd0);
    send_request(32'hFFFFFFFF);
    send_request(32'd13333334);
  endtask

  task automatic test_fast_clock();
    write_register(REG_INSTR_CLOCK, 32'hFFFFFFFF);
    write_register(REG_MAX_LINK, 32'hFFFFFFFF);
    send_request(32'hFFFFFFFF);
    send_request(32'hFFFFFFFE);
    send_request(32'd0);
    send_request(candidate_rate(PRI_DIV16, 3'd5));
  endtask

  task automatic test_zero_limit();
    write_register(REG_INSTR_CLOCK, INSTR_CLOCK_RST);
    write_register(REG_MAX_LINK, 32'd0);
    send_request(32'd5000000);     // only an exact match can win
    send_request(32'd5000001);
    send_request(32'd312500);
  endtask

  task automatic test_slow_clock();
    write_register(REG_INSTR_CLOCK, 32'd1);
    write_register(REG_MAX_LINK, MAX_LINK_RST);
    send_request(32'd0);           // zero request matches a zero rate
    send_request(32'd1);
    write_register(REG_INSTR_CLOCK, 32'd100);
    send_request(32'd0);
    send_request(32'd2);
    write_register(REG_INSTR_CLOCK, 32'd0);
    send_request(32'd7);
  endtask

  task automatic test_random_settings();
    int phase;
    int n;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      // first phase runs with no idling on either side
      in_idle_on = (phase != 0);
      out_idle_on = (phase != 0);
      case ($urandom_range(0, 4))
        0:       write_register(REG_INSTR_CLOCK, $urandom);
        1:       write_register(REG_INSTR_CLOCK, $urandom_range(1, 4000));
        2:       write_register(REG_INSTR_CLOCK, 32'hFFFFFFFF);
        default: write_register(REG_INSTR_CLOCK, $urandom_range(1000000, 200000000));
      endcase
      case ($urandom_range(0, 4))
        0:       write_register(REG_MAX_LINK, $urandom);
        1:       write_register(REG_MAX_LINK, 32'd0);
        2:       write_register(REG_MAX_LINK, 32'hFFFFFFFF);
        default: write_register(REG_MAX_LINK, $urandom_range(0, clock_hz));
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) send_request(random_request());
    end
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_settings();
    test_fast_clock();
    test_zero_limit();
    test_slow_clock();
    test_random_settings();
    drain_results();
    repeat (40) @(posedge clk);
    $display("ran %0d requests under %0d register settings in %0d cycles", requests_sent,
             settings_used, cycle_count);
    $display("%0d results checked, %0d with a usable prescaler pair", results_seen,
             found_seen);
    if (error_count == 0 && pending_picks.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", error_count, pending_picks.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
